>>> hw/rtl/rne_pkg.sv
`timescale 1ns / 1ps

package rne_pkg;

    // Width of the signed input and of the clamped magnitude.
    localparam int unsigned VALUE_W = 13;
    localparam int unsigned MAG_W   = 12;
    localparam int unsigned CHAR_W  = 7;

    // Default clamp limit for magnitudes.
    localparam int unsigned MAX_VALUE_DEF = 3999;

    // Entries of the queue between the front and back ends.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Number of entries in the numeral table.
    localparam int unsigned NUM_ENTRIES = 13;
    localparam int unsigned POS_W       = 4;

    // ASCII codes of the characters outside the numeral table.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h4F;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    // Greedy subtraction table, largest value first.
    localparam logic [MAG_W-1:0] STEP_VALUE [NUM_ENTRIES] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };

    // M C D C C X L X X I V I I
    localparam logic [CHAR_W-1:0] FIRST_LETTER [NUM_ENTRIES] = '{
        7'h4D, 7'h43, 7'h44, 7'h43, 7'h43, 7'h58, 7'h4C,
        7'h58, 7'h58, 7'h49, 7'h56, 7'h49, 7'h49
    };

    // Second letter of a subtractive pair; CHAR_NONE for a single letter.
    localparam logic [CHAR_W-1:0] SECOND_LETTER [NUM_ENTRIES] = '{
        CHAR_NONE, 7'h4D, CHAR_NONE, 7'h44, CHAR_NONE, 7'h43, CHAR_NONE,
        7'h4C, CHAR_NONE, 7'h58, CHAR_NONE, 7'h56, CHAR_NONE
    };

    // One classified job, as passed from the front end to the back end.
    typedef struct packed {
        logic             negative;
        logic             zero;
        logic [MAG_W-1:0] magnitude;
    } t_job;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_head;

endpackage

>>> hw/rtl/rne_value_if.sv
`timescale 1ns / 1ps

interface rne_value_if;
    logic                              valid;
    logic                              ready;
    logic signed [rne_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> hw/rtl/rne_char_if.sv
`timescale 1ns / 1ps

interface rne_char_if;
    logic                        valid;
    logic                        ready;
    logic [rne_pkg::CHAR_W-1:0]  char_code;
    logic                        last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> hw/rtl/rne_front.sv
`timescale 1ns / 1ps

module rne_front #(
    parameter int unsigned MAX_VALUE = rne_pkg::MAX_VALUE_DEF
) (
    rne_value_if.sink        i_value,
    input  logic             i_q_full,
    output logic             o_push,
    output rne_pkg::t_job    o_job
);

    logic                          negative;
    logic [rne_pkg::VALUE_W-1:0]   mag_full;
    logic [rne_pkg::VALUE_W-1:0]   mag_clamped;

    // Accept a transfer whenever the queue has room.
    assign i_value.ready = !i_q_full;
    assign o_push        = i_value.valid && !i_q_full;

    // Sign, magnitude and clamp. The most negative input negates to 4096,
    // which the unsigned compare clamps like any other large magnitude.
    always_comb begin
        negative = i_value.value[rne_pkg::VALUE_W-1];
        if (negative) begin
            mag_full = rne_pkg::VALUE_W'(-i_value.value);
        end else begin
            mag_full = rne_pkg::VALUE_W'(i_value.value);
        end
        if (mag_full > rne_pkg::VALUE_W'(MAX_VALUE)) begin
            mag_clamped = rne_pkg::VALUE_W'(MAX_VALUE);
        end else begin
            mag_clamped = mag_full;
        end
        o_job.negative  = negative;
        o_job.zero      = (mag_clamped == '0);
        o_job.magnitude = mag_clamped[rne_pkg::MAG_W-1:0];
    end

endmodule

>>> hw/rtl/rne_queue.sv
`timescale 1ns / 1ps

module rne_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rne_pkg::t_job        i_job,
    input  logic                 i_pop,
    output logic                 o_full,
    output rne_pkg::t_queue_head o_head
);

    localparam int unsigned DEPTH = rne_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rne_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    // Storage for queued jobs.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/rne_back.sv
`timescale 1ns / 1ps

module rne_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rne_pkg::t_queue_head i_head,
    output logic                 o_pop,
    rne_char_if.source           o_char
);

    // Conversion state.
    logic                         r_busy;
    logic                         r_neg_pending;
    logic                         r_second_pending;
    logic                         r_zero;
    logic [rne_pkg::MAG_W-1:0]    r_remaining;
    logic [rne_pkg::POS_W-1:0]    r_pos;

    // Output register.
    logic                         r_out_valid;
    logic [rne_pkg::CHAR_W-1:0]   r_char;
    logic                         r_last;

    logic                         load_en;
    logic                         emit;
    logic [rne_pkg::NUM_ENTRIES-1:0] fits;
    logic [rne_pkg::POS_W-1:0]    idx;
    logic [rne_pkg::MAG_W-1:0]    diff;
    logic [rne_pkg::CHAR_W-1:0]   n_char;
    logic                         n_last;
    logic                         n_neg_pending;
    logic                         n_second_pending;
    logic [rne_pkg::MAG_W-1:0]    n_remaining;
    logic [rne_pkg::POS_W-1:0]    n_pos;

    assign o_char.valid     = r_out_valid;
    assign o_char.char_code = r_char;
    assign o_char.last      = r_last;

    // The output register takes a new character when empty or being drained.
    assign load_en = !r_out_valid || o_char.ready;
    assign emit    = r_busy && load_en;
    assign o_pop   = !r_busy && i_head.valid;

    // Largest table entry that still fits; earlier entries never fit again,
    // so the first match is the greedy choice.
    always_comb begin
        for (int i = 0; i < rne_pkg::NUM_ENTRIES; i++) begin
            fits[i] = (r_remaining >= rne_pkg::STEP_VALUE[i]);
        end
        idx = rne_pkg::POS_W'(rne_pkg::NUM_ENTRIES - 1);
        for (int i = rne_pkg::NUM_ENTRIES - 1; i >= 0; i--) begin
            if (fits[i]) begin
                idx = rne_pkg::POS_W'(i);
            end
        end
        diff = r_remaining - rne_pkg::STEP_VALUE[idx];
    end

    // Choose the next character and the state it leaves behind.
    always_comb begin
        n_char           = rne_pkg::CHAR_ZERO;
        n_last           = 1'b1;
        n_neg_pending    = r_neg_pending;
        n_second_pending = r_second_pending;
        n_remaining      = r_remaining;
        n_pos            = r_pos;
        priority if (r_neg_pending) begin
            n_char        = rne_pkg::CHAR_MINUS;
            n_last        = 1'b0;
            n_neg_pending = 1'b0;
        end else if (r_second_pending) begin
            n_char           = rne_pkg::SECOND_LETTER[r_pos];
            n_last           = (r_remaining == '0);
            n_second_pending = 1'b0;
        end else if (r_zero) begin
            n_char = rne_pkg::CHAR_ZERO;
            n_last = 1'b1;
        end else begin
            n_char           = rne_pkg::FIRST_LETTER[idx];
            n_remaining      = diff;
            n_pos            = idx;
            n_second_pending = (rne_pkg::SECOND_LETTER[idx] != rne_pkg::CHAR_NONE);
            n_last           = !n_second_pending && (diff == '0);
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_neg_pending    <= 1'b0;
            r_second_pending <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy           <= 1'b1;
                r_neg_pending    <= i_head.job.negative;
                r_second_pending <= 1'b0;
                r_zero           <= i_head.job.zero;
                r_remaining      <= i_head.job.magnitude;
                r_pos            <= '0;
            end else if (emit) begin
                r_busy           <= !n_last;
                r_neg_pending    <= n_neg_pending;
                r_second_pending <= n_second_pending;
                r_remaining      <= n_remaining;
                r_pos            <= n_pos;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
                r_char      <= n_char;
                r_last      <= n_last;
            end else if (o_char.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A pending second letter or sign only exists inside a conversion.
    a_pending_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second_pending || r_neg_pending) |-> r_busy)
        else $error("pending character outside a conversion");

    // The sign always comes before any letter of a pair.
    a_sign_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_neg_pending |-> !r_second_pending)
        else $error("sign and second letter pending together");

    // A busy non-zero conversion with nothing pending must have magnitude left.
    a_work_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_neg_pending && !r_second_pending && !r_zero) |-> (r_remaining != '0))
        else $error("conversion busy with nothing left to emit");

    // The sequencer goes idle after a run's last character, so a new job is only taken once the previous run has ended.
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_last) |=> !r_busy)
        else $error("conversion did not end on its last character");

endmodule

>>> hw/rtl/roman_numeral_encoder_unit.sv
`timescale 1ns / 1ps
// Path: the first character of a value passes through the queue, the sequencer state and the output register.
// Throughput: the back end pops a new value from the queue only once the previous one is done,
// then emits one character per cycle from the shared greedy-subtraction sequencer while o_char is not stalled.
// The front end takes a new value whenever the two-entry queue has room.
// Reset is synchronous and active low; it empties the queue, the sequencer and the output.
module roman_numeral_encoder_unit #(
    parameter int unsigned MAX_VALUE = rne_pkg::MAX_VALUE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rne_value_if.sink   i_value,
    rne_char_if.source  o_char
);

    logic                 q_full;
    logic                 push;
    logic                 pop;
    rne_pkg::t_job        job;
    rne_pkg::t_queue_head head;

    // Classification of incoming values.
    rne_front #(
        .MAX_VALUE (MAX_VALUE)
    ) u_front (
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (job)
    );

    // Decoupling queue.
    rne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // Character sequencer.
    rne_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_char  (o_char)
    );

endmodule
